### hdl/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

    localparam int CFG_DATA_W = 64;

    localparam logic [0:0] REG_DELIM_LENGTH = 1'b0;
    localparam logic [0:0] REG_DELIM_BYTES  = 1'b1;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [6:0]  elem_index;
        logic [1:0]  kind;
        logic [15:0] elem_count;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD_CHAR,
        OP_MATCH,
        OP_HOLD,
        OP_SHIFT,
        OP_FLUSH,
        OP_CLOSE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has;
        logic fin;
        logic len_zero;
        logic byte_match;
        logic shift_stop;
        logic flush_done;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/dfs_ctrl.sv
`default_nettype none

module dfs_ctrl import dfs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  dp_status_t      status,
    input  wire logic       obuf_ok,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PROC   = 6'b000010,
        ST_SHIFT  = 6'b000100,
        ST_FLUSH  = 6'b001000,
        ST_CLOSE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (obuf_ok) begin
                    priority if (!status.has) begin
                        cmd.last = !status.fin;
                    end else if (status.len_zero) begin
                        cmd.op   = OP_ADD_CHAR;
                        cmd.last = !status.fin;
                    end else if (status.byte_match) begin
                        cmd.op   = OP_MATCH;
                        cmd.last = !status.fin;
                    end else begin
                        cmd.op = OP_HOLD;
                    end
                    if (status.has && !status.len_zero && !status.byte_match) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = status.fin ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                if (obuf_ok) begin
                    cmd.op   = OP_SHIFT;
                    cmd.last = status.shift_stop && !status.fin;
                    if (status.shift_stop) begin
                        state_next = status.fin ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (obuf_ok) begin
                    if (status.flush_done) begin
                        state_next = ST_CLOSE;
                    end else begin
                        cmd.op = OP_FLUSH;
                    end
                end
            end
            ST_CLOSE: begin
                if (obuf_ok) begin
                    cmd.op     = OP_CLOSE;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (obuf_ok) begin
                    cmd.op     = OP_FINISH;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/dfs_datapath.sv
`default_nettype none

module dfs_datapath import dfs_pkg::*; #(
    parameter int DELIM_MAX = 8,
    parameter int MAX_ELEMS = 128,
    parameter int ELEM_LEN  = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  in_item_t                   in_data,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    output logic                       res_push,
    output logic                       res_mark,
    output out_item_t                  res_data
);

    localparam int LEN_W = $clog2(ELEM_LEN);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(ELEM_LEN - 1);
    localparam logic [15:0] ELEMS_CAP = 16'(MAX_ELEMS);
    localparam logic [3:0] DMAX = 4'(DELIM_MAX);
    localparam int HOLD_W = DELIM_MAX * 8;

    function automatic logic [7:0] pick(input logic [63:0] v, input logic [2:0] i);
        return v[{i, 3'b000} +: 8];
    endfunction

    logic [3:0]        delim_length_reg, delim_length_next;
    logic [63:0]       delim_bytes_reg, delim_bytes_next;
    logic [7:0]        char_reg, char_next;
    logic              has_reg, has_next;
    logic              fin_reg, fin_next;
    logic [3:0]        depth_reg, depth_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [15:0]       total_reg, total_next;
    logic              open_reg, open_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [2:0]        fidx_reg, fidx_next;

    logic [3:0]  lim;
    logic [3:0]  eff_len;
    logic [3:0]  rem;
    logic        match_done;
    logic        shift_stop;
    logic        add_en;
    logic        close_en;
    logic        finish_en;
    logic [7:0]  byte_val;
    logic        len_room;
    logic [15:0] total_inc;

    // effective delimiter length: clamp, then cut at the first zero byte
    always_comb begin
        lim     = (delim_length_reg > DMAX) ? DMAX : delim_length_reg;
        eff_len = lim;
        for (int i = DELIM_MAX - 1; i >= 0; i--) begin
            if (4'(i) < lim && pick(delim_bytes_reg, 3'(i)) == 8'd0) begin
                eff_len = 4'(i);
            end
        end
    end

    assign match_done = (depth_reg + 4'd1) == eff_len;

    // remaining held bytes after dropping the head must form a delimiter prefix
    always_comb begin
        rem        = cnt_reg - 4'd1;
        shift_stop = 1'b1;
        for (int j = 0; j < DELIM_MAX - 1; j++) begin
            if (4'(j) < rem && hold_reg[(j + 1) * 8 +: 8] != pick(delim_bytes_reg, 3'(j))) begin
                shift_stop = 1'b0;
            end
        end
    end

    always_comb begin
        status.has        = has_reg;
        status.fin        = fin_reg;
        status.len_zero   = (eff_len == 4'd0);
        status.byte_match = (pick(delim_bytes_reg, depth_reg[2:0]) == char_reg);
        status.shift_stop = shift_stop;
        status.flush_done = ({1'b0, fidx_reg} == depth_reg);
    end

    assign len_room  = (length_reg < LEN_CAP);
    assign total_inc = (total_reg == 16'hFFFF) ? total_reg : total_reg + 16'd1;
    assign res_mark  = cmd.last;

    always_comb begin
        add_en    = 1'b0;
        close_en  = 1'b0;
        finish_en = 1'b0;
        byte_val  = 8'd0;
        unique case (cmd.op)
            OP_ADD_CHAR: begin
                add_en   = 1'b1;
                byte_val = char_reg;
            end
            OP_SHIFT: begin
                add_en   = 1'b1;
                byte_val = hold_reg[7:0];
            end
            OP_FLUSH: begin
                add_en   = 1'b1;
                byte_val = pick(delim_bytes_reg, fidx_reg);
            end
            OP_MATCH:  close_en  = match_done;
            OP_CLOSE:  close_en  = 1'b1;
            OP_FINISH: finish_en = 1'b1;
            default: begin
                add_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        res_push             = 1'b0;
        res_data.out_byte    = 8'd0;
        res_data.elem_index  = total_reg[6:0];
        res_data.kind        = KIND_BYTE;
        res_data.elem_count  = total_reg;
        res_data.last_of_run = cmd.last;
        priority if (add_en) begin
            res_push          = len_room && (total_reg < ELEMS_CAP);
            res_data.out_byte = byte_val;
        end else if (close_en) begin
            res_push            = open_reg;
            res_data.kind       = KIND_CLOSE;
            res_data.elem_count = total_inc;
        end else if (finish_en) begin
            res_push            = 1'b1;
            res_data.kind       = KIND_FINISH;
            res_data.elem_index = 7'd0;
        end else begin
            res_push = 1'b0;
        end
    end

    always_comb begin
        delim_length_next = delim_length_reg;
        delim_bytes_next  = delim_bytes_reg;
        char_next         = char_reg;
        has_next          = has_reg;
        fin_next          = fin_reg;
        depth_next        = depth_reg;
        length_next       = length_reg;
        total_next        = total_reg;
        open_next         = open_reg;
        hold_next         = hold_reg;
        cnt_next          = cnt_reg;
        fidx_next         = fidx_reg;

        if (add_en) begin
            open_next = 1'b1;
            if (len_room) begin
                length_next = length_reg + LEN_W'(1);
            end
        end
        if (close_en && open_reg) begin
            total_next  = total_inc;
            open_next   = 1'b0;
            length_next = '0;
        end

        unique case (cmd.op)
            OP_LOAD: begin
                char_next = in_data.char_byte;
                has_next  = in_data.has_byte;
                fin_next  = in_data.end_of_string;
            end
            OP_MATCH: begin
                depth_next = match_done ? 4'd0 : depth_reg + 4'd1;
            end
            OP_HOLD: begin
                for (int i = 0; i < DELIM_MAX; i++) begin
                    hold_next[i * 8 +: 8] = (4'(i) == depth_reg) ? char_reg
                                          : pick(delim_bytes_reg, 3'(i));
                end
                cnt_next = depth_reg + 4'd1;
            end
            OP_SHIFT: begin
                hold_next = hold_reg >> 8;
                cnt_next  = rem;
                if (shift_stop) begin
                    depth_next = rem;
                end
            end
            OP_FLUSH: begin
                fidx_next = fidx_reg + 3'd1;
            end
            OP_FINISH: begin
                total_next  = '0;
                length_next = '0;
                open_next   = 1'b0;
                depth_next  = '0;
                fidx_next   = '0;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase

        // a register write abandons any partial match
        if (cfg_wr_en) begin
            if (cfg_wr_index == REG_DELIM_LENGTH) begin
                delim_length_next = cfg_wr_data[3:0];
            end else begin
                delim_bytes_next = cfg_wr_data;
            end
            depth_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_length_reg <= '0;
            delim_bytes_reg  <= '0;
            depth_reg        <= '0;
            length_reg       <= '0;
            total_reg        <= '0;
            open_reg         <= 1'b0;
            cnt_reg          <= '0;
            fidx_reg         <= '0;
        end else begin
            delim_length_reg <= delim_length_next;
            delim_bytes_reg  <= delim_bytes_next;
            depth_reg        <= depth_next;
            length_reg       <= length_next;
            total_reg        <= total_next;
            open_reg         <= open_next;
            cnt_reg          <= cnt_next;
            fidx_reg         <= fidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        has_reg  <= has_next;
        fin_reg  <= fin_next;
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

### hdl/dfs_outbuf.sv
`default_nettype none

module dfs_outbuf import dfs_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  res_push,
    input  wire logic  res_mark,
    input  out_item_t  res_data,
    output logic       push_ok,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);

    logic      pend_valid_reg, pend_valid_next;
    out_item_t pend_data_reg, pend_data_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      out_free;
    logic      move;

    // one result is held back until it is known whether it ends the run
    assign out_free = !out_valid_reg || m_ready;
    assign push_ok  = !pend_valid_reg || out_free;
    assign move     = pend_valid_reg && out_free && (pend_data_reg.last_of_run || res_push);

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (move) begin
            out_valid_next = 1'b1;
            out_data_next  = pend_data_reg;
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        priority if (res_push) begin
            pend_valid_next = 1'b1;
            pend_data_next  = res_data;
        end else if (move) begin
            pend_valid_next = 1'b0;
        end else if (res_mark && pend_valid_reg) begin
            pend_data_next.last_of_run = 1'b1;
        end else begin
            pend_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

### hdl/delimiter_field_splitter_core.sv
// Splits a byte stream at each leftmost, non-overlapping occurrence of a
// delimiter of up to DELIM_MAX bytes, one source byte per request, and
// returns element bytes, element-closed and string-finished results, one per
// cycle while the output does not stall. Requests are taken one at a time:
// each is accepted, then decided; a mismatch walks the fallback chain one
// byte per cycle unless the output stalls; an end of string flushes each
// still-held byte, then takes the flush check, close and finish steps.
// Results leave through a one-entry hold stage and an output register, so
// the m_ side can stall without losing data; the core waits only when both
// are full. The user must write registers through cfg_wr_* only while no
// request is in flight; the block does not enforce this. A write drops any
// partly matched delimiter. No clearing pass is needed after reset.
`default_nettype none

module delimiter_field_splitter_core import dfs_pkg::*; #(
    parameter int DELIM_MAX = 8,
    parameter int MAX_ELEMS = 128,
    parameter int ELEM_LEN  = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [0:0]            cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       obuf_ok;
    logic       res_push;
    logic       res_mark;
    out_item_t  res_data;

    dfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .obuf_ok (obuf_ok),
        .cmd     (cmd)
    );

    dfs_datapath #(
        .DELIM_MAX (DELIM_MAX),
        .MAX_ELEMS (MAX_ELEMS),
        .ELEM_LEN  (ELEM_LEN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_data      (s_data),
        .cmd          (cmd),
        .status       (status),
        .res_push     (res_push),
        .res_mark     (res_mark),
        .res_data     (res_data)
    );

    dfs_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_push (res_push),
        .res_mark (res_mark),
        .res_data (res_data),
        .push_ok  (obuf_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

### hdl/dfs_checker.sv
`default_nettype none

module dfs_checker import dfs_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == KIND_BYTE || m_data.kind == KIND_CLOSE
                     || m_data.kind == KIND_FINISH))
        else $error("undefined result kind");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_BYTE |-> m_data.out_byte == 8'd0)
        else $error("nonzero byte on a non-byte result");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_FINISH
            |-> m_data.last_of_run && m_data.elem_index == 7'd0)
        else $error("string-finished result malformed");

endmodule

bind delimiter_field_splitter_core dfs_checker u_dfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dfs_pkg::*;

    localparam int DELIM_MAX = 8;
    localparam int MAX_ELEMS = 128;
    localparam int ELEM_LEN  = 256;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    delimiter_field_splitter_core #(
        .DELIM_MAX(DELIM_MAX),
        .MAX_ELEMS(MAX_ELEMS),
        .ELEM_LEN(ELEM_LEN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // splitter state as seen from the ports
    logic [3:0]  delim_len_q = '0;
    logic [63:0] delim_word = '0;
    int unsigned match_depth = 0;
    int unsigned elem_length = 0;
    int unsigned elem_total = 0;
    bit          elem_open = 1'b0;

    in_item_t    pending_chars[$];
    out_item_t   awaited_results[$];
    out_item_t   step_out[$];
    out_item_t   want_item;

    int unsigned mismatch_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_arm = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    function automatic logic [7:0] delim_at(int unsigned i);
        return delim_word[8*(i%8) +: 8];
    endfunction

    function automatic int unsigned active_delim_len();
        int unsigned n;
        n = 32'(delim_len_q);
        if (n > DELIM_MAX) n = DELIM_MAX;
        for (int unsigned i = 0; i < n; i++)
            if (delim_at(i) == 8'h00) return i;
        return n;
    endfunction

    function automatic void push_result(logic [7:0] b, int unsigned idx, logic [1:0] kind,
                                        int unsigned cnt);
        out_item_t r;
        r.out_byte    = b;
        r.elem_index  = idx[6:0];
        r.kind        = kind;
        r.elem_count  = cnt[15:0];
        r.last_of_run = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void keep_byte(logic [7:0] b);
        elem_open = 1'b1;
        if (elem_length < ELEM_LEN - 1) begin
            if (elem_total < MAX_ELEMS) push_result(b, elem_total, KIND_BYTE, elem_total);
            elem_length++;
        end
    endfunction

    function automatic void close_element();
        int unsigned idx;
        idx = elem_total;
        if (!elem_open) return;
        if (elem_total < 65535) elem_total++;
        push_result(8'h00, idx, KIND_CLOSE, elem_total);
        elem_open = 1'b0;
        elem_length = 0;
    endfunction

    function automatic void split_request(in_item_t req);
        int unsigned dlen;
        int unsigned d;
        int unsigned k;
        logic [7:0]  held [8];
        bit          ok;
        out_item_t   r;
        dlen = active_delim_len();
        step_out.delete();
        if (match_depth >= dlen) match_depth = 0;
        if (req.has_byte) begin
            if (dlen == 0) begin
                keep_byte(req.char_byte);
            end else if (delim_at(match_depth) == req.char_byte) begin
                match_depth++;
                if (match_depth == dlen) begin
                    close_element();
                    match_depth = 0;
                end
            end else begin
                // fall back to the longest delimiter prefix that ends the held bytes
                d = match_depth;
                for (int unsigned i = 0; i < d; i++) held[i] = delim_at(i);
                held[d] = req.char_byte;
                k = d;
                while (k > 0) begin
                    ok = 1'b1;
                    for (int unsigned j = 0; j < k; j++)
                        if (held[d + 1 - k + j] != delim_at(j)) ok = 1'b0;
                    if (ok) break;
                    k--;
                end
                for (int unsigned i = 0; i < d + 1 - k; i++) keep_byte(held[i]);
                match_depth = k;
            end
        end
        if (req.end_of_string) begin
            for (int unsigned i = 0; i < match_depth; i++) keep_byte(delim_at(i));
            match_depth = 0;
            close_element();
            push_result(8'h00, 0, KIND_FINISH, elem_total);
            elem_total = 0;
            elem_length = 0;
            elem_open = 1'b0;
        end
        foreach (step_out[i]) begin
            r = step_out[i];
            r.last_of_run = (i == step_out.size() - 1);
            awaited_results.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v,
                         got_v);
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) split_request(s_data);
            if (!s_valid || s_ready) begin
                if (pending_chars.size() != 0 && (no_idle || $urandom_range(0, 99) >= 38)) begin
                    s_data  <= pending_chars.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 100)
                        $display("%0t: unexpected result, expected none, actual %h", $time,
                                 m_data);
                end else begin
                    want_item = awaited_results.pop_front();
                    check_field("out_byte", 16'(want_item.out_byte), 16'(m_data.out_byte));
                    check_field("elem_index", 16'(want_item.elem_index),
                                16'(m_data.elem_index));
                    check_field("kind", 16'(want_item.kind), 16'(m_data.kind));
                    check_field("elem_count", want_item.elem_count, m_data.elem_count);
                    check_field("last_of_run", 16'(want_item.last_of_run),
                                16'(m_data.last_of_run));
                end
            end
            if (hold_arm && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    task automatic send_req(input logic [7:0] c, input logic has, input logic fin);
        in_item_t req;
        req.char_byte     = c;
        req.has_byte      = has;
        req.end_of_string = fin;
        while (pending_chars.size() >= 64) @(posedge aclk);
        pending_chars.push_back(req);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        if (idx == REG_DELIM_LENGTH) delim_len_q = value[3:0];
        else delim_word = value;
        match_depth = 0;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_chars.size() != 0 || s_valid || awaited_results.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_string_byte();
        int unsigned r;
        int unsigned dlen;
        dlen = active_delim_len();
        r = $urandom_range(0, 99);
        if (r < 50 && dlen > 0) return delim_at($urandom_range(0, dlen - 1));
        if (r < 75) return 8'h63;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_string(input int unsigned n_bytes, inout int unsigned sent);
        int unsigned dlen;
        int unsigned r;
        int unsigned cut;
        int unsigned added;
        dlen = active_delim_len();
        added = 0;
        while (added < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else if (r < 30 && dlen > 0) begin
                for (int unsigned i = 0; i < dlen; i++) send_req(delim_at(i), 1'b1, 1'b0);
                added += dlen;
            end else if (r < 42 && dlen > 1) begin
                // broken delimiter
                cut = $urandom_range(1, dlen - 1);
                for (int unsigned i = 0; i < cut; i++) send_req(delim_at(i), 1'b1, 1'b0);
                added += cut;
            end else begin
                send_req(pick_string_byte(), 1'b1, 1'b0);
                added++;
            end
        end
        send_req(pick_string_byte(), 1'($urandom_range(0, 1)), 1'b1);
        sent += added + 1;
    endtask

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned cfg_len;
        int unsigned r;
        int unsigned phase_sent;
        logic [63:0] cfg_word;
        logic [7:0]  fill;
        string       seq_text;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // no splitting
        write_reg(REG_DELIM_LENGTH, 64'd0);
        write_reg(REG_DELIM_BYTES, '1);
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'h00, 1'b1, 1'b0);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req(8'h5A, 1'b1, 1'b1);
        wait_drained();

        // two byte delimiter, leading, adjacent and trailing partial
        write_reg(REG_DELIM_BYTES, 64'h6261);
        write_reg(REG_DELIM_LENGTH, 64'd2);
        seq_text = "abxababya";
        foreach (seq_text[i]) send_req(seq_text[i], 1'b1, 1'b0);
        send_req(8'h00, 1'b0, 1'b1);
        wait_drained();

        // oversize length, deep fallback
        write_reg(REG_DELIM_BYTES, 64'h6261616161616161);
        write_reg(REG_DELIM_LENGTH, 64'd15);
        repeat (8) send_req(8'h61, 1'b1, 1'b0);
        send_req(8'h62, 1'b1, 1'b1);
        repeat (4) send_req(8'h61, 1'b1, 1'b0);
        wait_drained();

        // reconfigure mid match, zero byte cuts the delimiter
        write_reg(REG_DELIM_BYTES, 64'h0000_0063_0000_6261);
        write_reg(REG_DELIM_LENGTH, 64'd5);
        send_req(8'h63, 1'b1, 1'b0);
        send_req(8'h61, 1'b1, 1'b0);
        send_req(8'h62, 1'b1, 1'b0);
        send_req(8'h64, 1'b1, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                cfg_len  = 8;
                cfg_word = '1;
            end else if (p == 1) begin
                cfg_len  = 8;
                cfg_word = '0;
            end else begin
                cfg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                      : $urandom_range(0, 8);
                for (int b = 0; b < 8; b++) begin
                    r = $urandom_range(0, 99);
                    if (r < 6) cfg_word[8*b +: 8] = 8'h00;
                    else if (r < 16) cfg_word[8*b +: 8] = 8'($urandom_range(1, 255));
                    else cfg_word[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 1));
                end
            end
            if (p % 2 == 0) begin
                write_reg(REG_DELIM_LENGTH, 64'(cfg_len));
                write_reg(REG_DELIM_BYTES, cfg_word);
            end else begin
                write_reg(REG_DELIM_BYTES, cfg_word);
                write_reg(REG_DELIM_LENGTH, 64'(cfg_len));
            end
            if (p == 3) hold_arm = 1'b1;
            phase_sent = 0;
            while (phase_sent < 8) send_random_string($urandom_range(0, 12), phase_sent);
            wait_drained();
        end

        // element longer than the clip length
        write_reg(REG_DELIM_BYTES, 64'h6261);
        write_reg(REG_DELIM_LENGTH, 64'd2);
        no_idle = 1'b1;
        repeat (256) begin
            fill = ($urandom_range(0, 99) < 5) ? 8'h00 : 8'h63 + 8'($urandom_range(0, 20));
            send_req(fill, 1'b1, 1'b0);
        end
        send_req(8'h61, 1'b1, 1'b0);
        send_req(8'h62, 1'b1, 1'b0);
        send_req(8'h64, 1'b1, 1'b1);
        wait_drained();
        no_idle = 1'b0;

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
